/* hw/rtl/rpd_pkg.sv */
// ----------------------------------------------------------------------------
// RSSI presence detector package
// Shared types, register indexes, reset values and constants of the detector.
// ----------------------------------------------------------------------------
package rpd_pkg;

    // Defaults for the top-level parameters.
    localparam int unsigned HIT_DEPTH_DEF       = 128;
    localparam int unsigned STARTUP_SILENCE_DEF = 4000;

    // Company identifier that an advertisement must carry to be counted.
    localparam logic [15:0] WANTED_COMPANY = 16'h004C;

    // Gap reported when no strong hit is stored or the gap is too large.
    localparam logic [19:0] GAP_NONE = 20'd999999;

    // Level reported before any advertisement has been stored.
    localparam logic signed [7:0] LEVEL_INIT = -8'sd127;

    // Item commands.
    localparam logic CMD_ADVERT = 1'b0;
    localparam logic CMD_EVAL   = 1'b1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_STRONG_THR   = 3'd0,
        CFG_VERY_THR     = 3'd1,
        CFG_HITS_REQ     = 3'd2,
        CFG_PRUNE_AGE    = 3'd3,
        CFG_VERY_AGE_MS  = 3'd4,
        CFG_HOLD_GAP     = 3'd5
    } cfg_idx_t;

    // Configuration reset values.
    localparam logic signed [7:0] STRONG_THR_RST  = -8'sd56;
    localparam logic signed [7:0] VERY_THR_RST    = -8'sd52;
    localparam logic [2:0]        HITS_REQ_RST    = 3'd2;
    localparam logic [15:0]       PRUNE_AGE_RST   = 16'd20000;
    localparam logic [15:0]       VERY_AGE_MS_RST = 16'd15000;
    localparam logic [17:0]       HOLD_GAP_RST    = 18'd60000;

    localparam int unsigned CFG_DATA_W = 18;

    typedef struct packed {
        logic signed [7:0] strong_thr;
        logic signed [7:0] very_thr;
        logic [2:0]        hits_required;
        logic [15:0]       prune_age;
        logic [15:0]       very_age_ms;
        logic [17:0]       hold_gap;
    } cfg_t;

    // One stored hit: time stamp and signal level.
    typedef struct packed {
        logic [31:0]       stamp;
        logic signed [7:0] level;
    } hit_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic append;
        logic eval_start;
        logic scan;
        logic finish;
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic eval_live;
        logic scan_done;
        logic out_free;
    } ctrl_status_t;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_DECIDE = 3'b100
    } state_t;

endpackage

/* hw/rtl/rpd_item_if.sv */
// ----------------------------------------------------------------------------
// Item channel
// Valid/ready channel that carries one advertisement or evaluation item.
// ----------------------------------------------------------------------------
interface rpd_item_if;
    logic              valid;
    logic              ready;
    logic              command;
    logic [31:0]       time_ms;
    logic signed [7:0] rssi;
    logic              company_present;
    logic [15:0]       company_id;

    modport source (
        output valid, command, time_ms, rssi, company_present, company_id,
        input  ready
    );
    modport sink (
        input  valid, command, time_ms, rssi, company_present, company_id,
        output ready
    );
endinterface

/* hw/rtl/rpd_result_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one presence decision.
// ----------------------------------------------------------------------------
interface rpd_result_if;
    logic              valid;
    logic              ready;
    logic              present;
    logic              changed;
    logic [7:0]        strong_count;
    logic              very_recent;
    logic [19:0]       strong_gap_ms;
    logic signed [7:0] last_strong_rssi;

    modport source (
        output valid, present, changed, strong_count, very_recent, strong_gap_ms,
               last_strong_rssi,
        input  ready
    );
    modport sink (
        input  valid, present, changed, strong_count, very_recent, strong_gap_ms,
               last_strong_rssi,
        output ready
    );
endinterface

/* hw/rtl/rssi_presence_detector_core.sv */
// ----------------------------------------------------------------------------
// RSSI presence detector core
// Decides presence from stored strong advertisement hits on periodic evaluation.
// ----------------------------------------------------------------------------
// An advertisement transfer is stored as it is taken and gives no result.
// An evaluation past the startup silence scans the stored hits, one entry per
// cycle, then decides; the next item can be taken in the same cycle its result appears.
// A result waits in the output register; a later evaluation holds before it.
// Reset loads the register defaults and empties the store; there is no clearing pass.
module rssi_presence_detector_core
    import rpd_pkg::*;
#(
    parameter int unsigned HIT_DEPTH       = HIT_DEPTH_DEF,
    parameter int unsigned STARTUP_SILENCE = STARTUP_SILENCE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  write_enable,
    input  logic [2:0]            write_index,
    input  logic [CFG_DATA_W-1:0] write_data,
    rpd_item_if.sink              items,
    rpd_result_if.source          results
);

    // Configuration registers. The user must write them only while the block
    // is idle; the block does not enforce it. The datapath reads them directly
    // with no shadow copy. A write to an index beyond the last register is dropped.
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strong_thr    <= STRONG_THR_RST;
            cfg_reg.very_thr      <= VERY_THR_RST;
            cfg_reg.hits_required <= HITS_REQ_RST;
            cfg_reg.prune_age     <= PRUNE_AGE_RST;
            cfg_reg.very_age_ms   <= VERY_AGE_MS_RST;
            cfg_reg.hold_gap      <= HOLD_GAP_RST;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                CFG_STRONG_THR:  cfg_reg.strong_thr    <= $signed(write_data[7:0]);
                CFG_VERY_THR:    cfg_reg.very_thr      <= $signed(write_data[7:0]);
                CFG_HITS_REQ:    cfg_reg.hits_required <= write_data[2:0];
                CFG_PRUNE_AGE:   cfg_reg.prune_age     <= write_data[15:0];
                CFG_VERY_AGE_MS: cfg_reg.very_age_ms   <= write_data[15:0];
                CFG_HOLD_GAP:    cfg_reg.hold_gap      <= write_data[17:0];
                default:
                begin
                end
            endcase
        end
    end

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic         in_ready;

    // The controller only accepts items in idle. An advertisement is stored
    // in the accepting cycle; an evaluation during the startup silence is
    // consumed without effect; any other evaluation starts a scan.
    rpd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (items.valid),
        .in_command (items.command),
        .in_ready   (in_ready),
        .status     (status),
        .cmd        (cmd)
    );

    assign items.ready = in_ready;

    // The datapath holds the circular hit store. The scan reads each stored
    // hit once, writes the ones still inside the window back in order, and
    // accumulates the strong count, the very-strong flag and the age of the
    // newest strong hit for the decision.
    rpd_datapath #(
        .HIT_DEPTH       (HIT_DEPTH),
        .STARTUP_SILENCE (STARTUP_SILENCE)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .status          (status),
        .time_ms         (items.time_ms),
        .rssi            (items.rssi),
        .company_present (items.company_present),
        .company_id      (items.company_id),
        .results         (results)
    );

endmodule

/* hw/rtl/rpd_ctrl.sv */
// ----------------------------------------------------------------------------
// RSSI presence detector controller
// Sequences item intake, the hit store scan and the final decision.
// ----------------------------------------------------------------------------
module rpd_ctrl
    import rpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_command,
    output logic         in_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_command == CMD_ADVERT)
                    begin
                        cmd.append = 1'b1;
                    end
                    else if (status.eval_live)
                    begin
                        cmd.eval_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/rpd_datapath.sv */
// ----------------------------------------------------------------------------
// RSSI presence detector datapath
// Circular hit store, in-place pruning scan, accumulators and result register.
// ----------------------------------------------------------------------------
module rpd_datapath
    import rpd_pkg::*;
#(
    parameter int unsigned HIT_DEPTH       = HIT_DEPTH_DEF,
    parameter int unsigned STARTUP_SILENCE = STARTUP_SILENCE_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  ctrl_cmd_t         cmd,
    output ctrl_status_t      status,
    input  logic [31:0]       time_ms,
    input  logic signed [7:0] rssi,
    input  logic              company_present,
    input  logic [15:0]       company_id,
    rpd_result_if.source      results
);

    localparam int AW = $clog2(HIT_DEPTH);
    localparam int CW = $clog2(HIT_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(HIT_DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S   = SW'(HIT_DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(HIT_DEPTH);

    // Hit store and its registered read port.
    hit_t mem [HIT_DEPTH];
    hit_t rd_data_reg;

    // Store bookkeeping.
    logic [AW-1:0]     head_reg;
    logic [CW-1:0]     total_reg;
    logic signed [7:0] latest_reg;
    logic              present_reg;
    logic              startup_done_reg;

    // Scan state.
    logic [CW-1:0] idx_reg;
    logic [AW-1:0] rp_reg;
    logic [AW-1:0] wp_reg;
    logic [CW-1:0] kept_reg;
    logic          rd_valid_reg;
    logic [CW-1:0] count_reg;
    logic          very_reg;
    logic          found_reg;
    logic          first_reg;
    logic [31:0]   gap_reg;
    logic [31:0]   now_reg;

    // Result register.
    logic              out_valid_reg;
    logic              out_present_reg;
    logic              out_changed_reg;
    logic [7:0]        out_count_reg;
    logic              out_very_reg;
    logic [19:0]       out_gap_reg;
    logic signed [7:0] out_level_reg;

    logic          store_full;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] tail_wrap;
    logic [AW-1:0] tail_addr;
    logic          adv_hit;
    logic          issue;
    logic [31:0]   age;
    logic          in_window;
    logic          keep;
    logic          is_strong;
    logic          is_very;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    hit_t          mem_wdata;
    logic [8:0]    cnt9;
    logic          want;
    logic          changed;
    logic [19:0]   gap_out;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_ADDR) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        store_full = (total_reg == DEPTH_C);
        tail_sum   = SW'(head_reg) + SW'(total_reg);
        tail_wrap  = (tail_sum >= DEPTH_S) ? (tail_sum - DEPTH_S) : tail_sum;
        tail_addr  = tail_wrap[AW-1:0];

        adv_hit = company_present && (company_id == WANTED_COMPANY) &&
                  (rssi >= cfg.strong_thr);

        issue     = cmd.scan && (idx_reg != total_reg);
        age       = now_reg - rd_data_reg.stamp;
        in_window = (age <= 32'(cfg.prune_age));
        keep      = cmd.scan && rd_valid_reg && in_window;
        is_strong = ($signed(rd_data_reg.level) >= cfg.strong_thr);
        is_very   = ($signed(rd_data_reg.level) >= cfg.very_thr) &&
                    (age <= 32'(cfg.very_age_ms));

        // Kept entries are written back behind the read pointer.
        mem_we    = (cmd.append && adv_hit) || keep;
        if (keep)
        begin
            mem_waddr = wp_reg;
            mem_wdata = rd_data_reg;
        end
        else
        begin
            mem_waddr = store_full ? head_reg : tail_addr;
            mem_wdata = '{stamp: time_ms, level: rssi};
        end

        cnt9    = 9'(count_reg);
        want    = ((cnt9 >= 9'(cfg.hits_required)) && very_reg) ||
                  (present_reg && found_reg && (gap_reg <= 32'(cfg.hold_gap)));
        changed = first_reg || (want != present_reg);
        gap_out = (found_reg && (gap_reg <= 32'(GAP_NONE))) ? gap_reg[19:0] : GAP_NONE;

        status.eval_live = startup_done_reg || (time_ms >= 32'(STARTUP_SILENCE));
        status.scan_done = (idx_reg == total_reg) && !rd_valid_reg;
        status.out_free  = !out_valid_reg || results.ready;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rp_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            total_reg        <= '0;
            latest_reg       <= LEVEL_INIT;
            present_reg      <= 1'b0;
            startup_done_reg <= 1'b0;
            idx_reg          <= '0;
            rp_reg           <= '0;
            wp_reg           <= '0;
            kept_reg         <= '0;
            rd_valid_reg     <= 1'b0;
            count_reg        <= '0;
            very_reg         <= 1'b0;
            found_reg        <= 1'b0;
            first_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.append && adv_hit)
            begin
                latest_reg <= rssi;
                if (store_full)
                begin
                    head_reg <= ptr_inc(head_reg);
                end
                else
                begin
                    total_reg <= total_reg + 1'b1;
                end
            end

            if (cmd.eval_start)
            begin
                first_reg        <= !startup_done_reg;
                startup_done_reg <= 1'b1;
                if (!startup_done_reg)
                begin
                    present_reg <= 1'b0;
                end
                idx_reg      <= '0;
                rp_reg       <= head_reg;
                wp_reg       <= head_reg;
                kept_reg     <= '0;
                rd_valid_reg <= 1'b0;
                count_reg    <= '0;
                very_reg     <= 1'b0;
                found_reg    <= 1'b0;
            end

            if (cmd.scan)
            begin
                rd_valid_reg <= issue;
                if (issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                    rp_reg  <= ptr_inc(rp_reg);
                end
                if (keep)
                begin
                    wp_reg   <= ptr_inc(wp_reg);
                    kept_reg <= kept_reg + 1'b1;
                    if (is_strong)
                    begin
                        count_reg <= count_reg + 1'b1;
                        found_reg <= 1'b1;
                    end
                    if (is_very)
                    begin
                        very_reg <= 1'b1;
                    end
                end
            end

            if (cmd.finish)
            begin
                total_reg     <= kept_reg;
                present_reg   <= want;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.eval_start)
        begin
            now_reg <= time_ms;
            gap_reg <= '0;
        end
        if (keep && is_strong)
        begin
            gap_reg <= age;
        end
        if (cmd.finish)
        begin
            out_present_reg <= want;
            out_changed_reg <= changed;
            out_count_reg   <= cnt9[8] ? 8'd255 : cnt9[7:0];
            out_very_reg    <= very_reg;
            out_gap_reg     <= gap_out;
            out_level_reg   <= latest_reg;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.present          = out_present_reg;
    assign results.changed          = out_changed_reg;
    assign results.strong_count     = out_count_reg;
    assign results.very_recent      = out_very_reg;
    assign results.strong_gap_ms    = out_gap_reg;
    assign results.last_strong_rssi = out_level_reg;

    // The store never holds more hits than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= DEPTH_C)
        else $error("hit store count exceeds its depth");

    // Compaction never keeps more entries than it has read.
    assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= idx_reg)
        else $error("kept entries exceed entries read");

    // Read data is only marked valid after a read was issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(issue))
        else $error("read data valid without a read");

    // A decision is presented right after it is made, with the new presence.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (results.valid && (results.present == present_reg)))
        else $error("decision not presented after finish");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Presence detector testbench
// Drives advertisement and evaluation transfers into the detector core under
// several register settings, predicts every presence decision and compares
// each decision transfer, field by field, against the prediction.
// ----------------------------------------------------------------------------
module tb_top
    import rpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes that the block must ignore.
    localparam logic [2:0] CFG_UNUSED_A = 3'd6;
    localparam logic [2:0] CFG_UNUSED_B = 3'd7;

    // Number of register settings the run walks through, the reset one included.
    localparam int SETTING_COUNT = 8;

    // Transfers per setting that are evaluations or adverts from the wanted company.
    localparam int USEFUL_PER_SETTING = 50;

    // Length of each deliberate hold-off on the decision channel, in cycles.
    localparam int HOLD_CYCLES = 1500;

    // A slow but correct run stays far below this many cycles.
    localparam int CYCLE_LIMIT = 2500000;

    // One item as it crosses the item channel.
    typedef struct {
        logic              command;
        logic [31:0]       time_ms;
        logic signed [7:0] rssi;
        logic              company_present;
        logic [15:0]       company_id;
    } item_t;

    // One presence decision as it crosses the result channel.
    typedef struct {
        logic              present;
        logic              changed;
        logic [7:0]        strong_count;
        logic              very_recent;
        logic [19:0]       strong_gap_ms;
        logic signed [7:0] last_strong_rssi;
    } decision_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the hit store, the presence state and
    // the registers, and queues the decision that each evaluation must give.
    // ------------------------------------------------------------------------
    class presence_scoreboard;
        cfg_t              cfg;
        hit_t              hits[$];
        logic              is_present;
        logic              startup_done;
        logic signed [7:0] last_level;
        decision_t         expected_decisions[$];
        int                mismatches;
        int                decisions_checked;
        int                evals_taken;
        int                hits_stored;
        int                hits_dropped;
        int                entries;

        function new();
            cfg.strong_thr    = STRONG_THR_RST;
            cfg.very_thr      = VERY_THR_RST;
            cfg.hits_required = HITS_REQ_RST;
            cfg.prune_age     = PRUNE_AGE_RST;
            cfg.very_age_ms   = VERY_AGE_MS_RST;
            cfg.hold_gap      = HOLD_GAP_RST;
            is_present        = 1'b0;
            startup_done      = 1'b0;
            last_level        = LEVEL_INIT;
            mismatches        = 0;
            decisions_checked = 0;
            evals_taken       = 0;
            hits_stored       = 0;
            hits_dropped      = 0;
            entries           = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_STRONG_THR:  cfg.strong_thr    = data[7:0];
                CFG_VERY_THR:    cfg.very_thr      = data[7:0];
                CFG_HITS_REQ:    cfg.hits_required = data[2:0];
                CFG_PRUNE_AGE:   cfg.prune_age     = data[15:0];
                CFG_VERY_AGE_MS: cfg.very_age_ms   = data[15:0];
                CFG_HOLD_GAP:    cfg.hold_gap      = data[17:0];
                default: ;
            endcase
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] decision mismatch: %s", $time, msg);
        endtask

        // Applies one accepted item to the model state and, for an evaluation
        // past the startup silence, queues the decision it must produce.
        function void note_item(item_t it);
            hit_t      kept[$];
            logic [31:0] age;
            logic [31:0] gap;
            int        count;
            bit        found;
            bit        very;
            bit        want;
            bit        first;
            decision_t d;

            if (it.command == CMD_ADVERT) begin
                if (it.company_present && it.company_id == WANTED_COMPANY &&
                    it.rssi >= cfg.strong_thr) begin
                    // A full store loses its oldest hit.
                    if (hits.size() >= HIT_DEPTH_DEF) begin
                        void'(hits.pop_front());
                        hits_dropped++;
                    end
                    hits.push_back('{stamp: it.time_ms, level: it.rssi});
                    last_level = it.rssi;
                    hits_stored++;
                end
                return;
            end

            first = 1'b0;
            if (!startup_done) begin
                if (it.time_ms < STARTUP_SILENCE_DEF)
                    return;
                startup_done = 1'b1;
                is_present   = 1'b0;
                first        = 1'b1;
            end
            evals_taken++;

            // Ages wrap modulo 2^32, so a stamp from the future looks very old.
            foreach (hits[i]) begin
                age = it.time_ms - hits[i].stamp;
                if (age <= cfg.prune_age)
                    kept.push_back(hits[i]);
            end
            hits = kept;

            count = 0;
            found = 1'b0;
            very  = 1'b0;
            gap   = '0;
            foreach (hits[i]) begin
                age = it.time_ms - hits[i].stamp;
                if (hits[i].level >= cfg.strong_thr) begin
                    count++;
                    found = 1'b1;
                    gap   = age;
                end
                if (hits[i].level >= cfg.very_thr && age <= cfg.very_age_ms)
                    very = 1'b1;
            end

            want = (count >= cfg.hits_required && very) ||
                   (is_present && found && gap <= cfg.hold_gap);
            if (want && !is_present)
                entries++;

            d.present          = want;
            d.changed          = first || (want != is_present);
            d.strong_count     = (count > 255) ? 8'd255 : count[7:0];
            d.very_recent      = very;
            d.strong_gap_ms    = (!found || gap > GAP_NONE) ? GAP_NONE : gap[19:0];
            d.last_strong_rssi = last_level;
            is_present         = want;
            expected_decisions.push_back(d);
        endfunction

        task check_result(decision_t got);
            decision_t want;
            if (expected_decisions.size() == 0) begin
                report("decision transfer with no evaluation pending");
                return;
            end
            want = expected_decisions.pop_front();
            decisions_checked++;
            if (got.present !== want.present)
                report($sformatf("present got %0b, expected %0b", got.present, want.present));
            if (got.changed !== want.changed)
                report($sformatf("changed got %0b, expected %0b", got.changed, want.changed));
            if (got.strong_count !== want.strong_count)
                report($sformatf("strong_count got %0d, expected %0d",
                                 got.strong_count, want.strong_count));
            if (got.very_recent !== want.very_recent)
                report($sformatf("very_recent got %0b, expected %0b",
                                 got.very_recent, want.very_recent));
            if (got.strong_gap_ms !== want.strong_gap_ms)
                report($sformatf("strong_gap_ms got %0d, expected %0d",
                                 got.strong_gap_ms, want.strong_gap_ms));
            if (got.last_strong_rssi !== want.last_strong_rssi)
                report($sformatf("last_strong_rssi got %0d, expected %0d",
                                 got.last_strong_rssi, want.last_strong_rssi));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  write_enable;
    logic [2:0]            write_index;
    logic [CFG_DATA_W-1:0] write_data;

    rpd_item_if   item_ch();
    rpd_result_if result_ch();

    rssi_presence_detector_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .items        (item_ch),
        .results      (result_ch)
    );

    presence_scoreboard sb = new();

    // Timestamp that the traffic generator advances item by item.
    logic [31:0] clock_ms;

    // When set, neither side adds random pauses of its own: items are offered back to back.
    bit calm;

    // Set by the pressure process while the decision channel is held off.
    bit hold_off;

    int cycles;

    item_t     seen_item;
    decision_t seen_decision;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The timeout watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped after %0d cycles without finishing.", cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // Both channels are sampled at the rising edge. The decision is checked
    // before the item of the same edge is noted; the two can never belong to
    // the same evaluation anyway.
    always @(posedge clk) begin
        if (rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                seen_decision.present          = result_ch.present;
                seen_decision.changed          = result_ch.changed;
                seen_decision.strong_count     = result_ch.strong_count;
                seen_decision.very_recent      = result_ch.very_recent;
                seen_decision.strong_gap_ms    = result_ch.strong_gap_ms;
                seen_decision.last_strong_rssi = result_ch.last_strong_rssi;
                sb.check_result(seen_decision);
            end
            if (item_ch.valid && item_ch.ready) begin
                seen_item.command         = item_ch.command;
                seen_item.time_ms         = item_ch.time_ms;
                seen_item.rssi            = item_ch.rssi;
                seen_item.company_present = item_ch.company_present;
                seen_item.company_id      = item_ch.company_id;
                sb.note_item(seen_item);
            end
        end
    end

    // Decision receiver. Ready changes only at the falling edge; in calm
    // stretches it stays high unless the pressure process holds it off.
    initial begin
        int stall_left;
        stall_left = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off) begin
                result_ch.ready = 1'b0;
            end
            else if (stall_left > 0) begin
                result_ch.ready = 1'b0;
                stall_left--;
            end
            else begin
                result_ch.ready = 1'b1;
                if (!calm)
                    stall_left = pick_pause();
            end
        end
    end

    // Twice during the run the receiver stops taking decisions for a long
    // stretch. The sender keeps offering items, so the output register fills
    // up and the block has to push back on its item channel.
    initial begin
        int marks[2];
        marks[0] = 30;
        marks[1] = 70;
        hold_off = 1'b0;
        for (int k = 0; k < 2; k++) begin
            while (sb.decisions_checked < marks[k])
                @(negedge clk);
            hold_off = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_off = 1'b0;
        end
    end

    // Offers one item and returns at the falling edge after its transfer,
    // possibly after an idle gap. With no gap, valid simply stays high.
    task automatic send_item(input logic cmd, input logic [31:0] stamp,
                             input logic signed [7:0] level, input logic cp,
                             input logic [15:0] cid);
        int gap;
        item_ch.command         = cmd;
        item_ch.time_ms         = stamp;
        item_ch.rssi            = level;
        item_ch.company_present = cp;
        item_ch.company_id      = cid;
        item_ch.valid           = 1'b1;
        do
            @(posedge clk);
        while (!item_ch.ready);
        @(negedge clk);
        gap = calm ? 0 : pick_pause();
        if (gap > 0) begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // One register write per cycle; the caller drops the enable afterwards.
    task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] data);
        write_enable = 1'b1;
        write_index  = idx;
        write_data   = data;
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    // Writes all six registers, with junk in the bits above each register's
    // width, plus one write to an index the block must ignore.
    task automatic apply_setting(input cfg_t s);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom());
        write_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B, junk);
        junk = CFG_DATA_W'($urandom());
        junk[7:0] = s.strong_thr;
        write_reg(CFG_STRONG_THR, junk);
        junk = CFG_DATA_W'($urandom());
        junk[7:0] = s.very_thr;
        write_reg(CFG_VERY_THR, junk);
        junk = CFG_DATA_W'($urandom());
        junk[2:0] = s.hits_required;
        write_reg(CFG_HITS_REQ, junk);
        junk = CFG_DATA_W'($urandom());
        junk[15:0] = s.prune_age;
        write_reg(CFG_PRUNE_AGE, junk);
        junk = CFG_DATA_W'($urandom());
        junk[15:0] = s.very_age_ms;
        write_reg(CFG_VERY_AGE_MS, junk);
        write_reg(CFG_HOLD_GAP, s.hold_gap);
        write_enable = 1'b0;
    endtask

    // Waits until every pending decision has arrived, then lets an evaluation
    // that may still be scanning the store run out before registers change.
    task automatic settle();
        item_ch.valid = 1'b0;
        while (sb.expected_decisions.size() != 0)
            @(negedge clk);
        repeat (HIT_DEPTH_DEF + 8) @(negedge clk);
    endtask

    // Register settings: both ends of each documented range, the ends of the
    // register widths (a zero hit count and zero windows among them), then
    // random settings inside the documented ranges.
    function automatic cfg_t make_setting(int k);
        cfg_t s;
        case (k)
            1: s = '{-8'sd95, -8'sd95, 3'd1, 16'd1000, 16'd500, 18'd1000};
            2: s = '{-8'sd40, -8'sd40, 3'd6, 16'd60000, 16'd60000, 18'd180000};
            3: s = '{-8'sd70, -8'sd60, 3'd0, 16'd30000, 16'd10000, 18'd5000};
            4: s = '{8'sh80, 8'sd127, 3'd7, 16'd65535, 16'd65535, 18'd262143};
            5: s = '{8'sd127, 8'sh80, 3'd3, 16'd0, 16'd0, 18'd0};
            default: begin
                s.strong_thr    = 8'(int'($urandom_range(0, 55)) - 95);
                s.very_thr      = 8'(int'($urandom_range(0, 55)) - 95);
                s.hits_required = 3'($urandom_range(1, 6));
                s.prune_age     = 16'($urandom_range(1000, 60000));
                s.very_age_ms   = 16'($urandom_range(500, 60000));
                s.hold_gap      = 18'($urandom_range(1000, 180000));
            end
        endcase
        return s;
    endfunction

    // A signal level close to one of the two thresholds, so that both sides
    // of each comparison come up often.
    function automatic logic signed [7:0] near_level();
        int base;
        int v;
        base = $urandom_range(0, 1) ? int'(sb.cfg.strong_thr) : int'(sb.cfg.very_thr);
        v = base + int'($urandom_range(0, 24)) - 8;
        if (v > 127)
            v = 127;
        if (v < -128)
            v = -128;
        return v[7:0];
    endfunction

    // Random traffic. Most items are well-formed adverts from the wanted
    // company with levels near the thresholds, interleaved with evaluation
    // ticks; the rest is random noise, mostly ignored. Now and then time
    // jumps far ahead or anywhere, and some adverts carry a future stamp.
    // A burst of more hits than the store holds forces the oldest out.
    task automatic run_traffic(input int target, input bit force_burst);
        int useful;
        int r;
        int n;
        int thr;
        logic [15:0] cid;
        useful = 0;
        while (useful < target) begin
            if (force_burst || $urandom_range(0, 399) == 0) begin
                force_burst = 1'b0;
                n = HIT_DEPTH_DEF + $urandom_range(2, 20);
                thr = int'(sb.cfg.strong_thr);
                for (int i = 0; i < n; i++) begin
                    clock_ms += $urandom_range(0, 3);
                    send_item(CMD_ADVERT, clock_ms,
                              8'(thr + int'($urandom_range(0, 127 - thr))),
                              1'b1, WANTED_COMPANY);
                end
                send_item(CMD_EVAL, clock_ms, 8'($urandom()), 1'($urandom()),
                          16'($urandom()));
                useful += n + 1;
                continue;
            end

            r = $urandom_range(0, 99);
            if (r < 2)
                clock_ms = $urandom();
            else if (r < 6)
                clock_ms += $urandom_range(1000, 70000);
            else
                clock_ms += $urandom_range(0, 300);

            r = $urandom_range(0, 99);
            if (r < 30) begin
                // Evaluation; the advert fields are don't-care and random.
                send_item(CMD_EVAL, clock_ms, 8'($urandom()), 1'($urandom()),
                          16'($urandom()));
                useful++;
            end
            else if (r < 85) begin
                if ($urandom_range(0, 24) == 0)
                    send_item(CMD_ADVERT, clock_ms + $urandom_range(1, 5000), near_level(),
                              1'b1, WANTED_COMPANY);
                else
                    send_item(CMD_ADVERT, clock_ms, near_level(), 1'b1, WANTED_COMPANY);
                useful++;
            end
            else begin
                r = $urandom_range(0, 2);
                if (r == 0)
                    cid = 16'($urandom());
                else if (r == 1)
                    cid = WANTED_COMPANY ^ (16'h0001 << $urandom_range(0, 15));
                else
                    cid = WANTED_COMPANY;
                send_item(CMD_ADVERT, clock_ms, 8'($urandom()), 1'($urandom_range(0, 1)),
                          cid);
            end
        end
    endtask

    // Main sequence: reset, directed items at the reset setting, then random
    // traffic under each register setting in turn.
    initial begin
        rst_n                   = 1'b0;
        write_enable            = 1'b0;
        write_index             = CFG_STRONG_THR;
        write_data              = '0;
        item_ch.valid           = 1'b0;
        item_ch.command         = CMD_ADVERT;
        item_ch.time_ms         = '0;
        item_ch.rssi            = '0;
        item_ch.company_present = 1'b0;
        item_ch.company_id      = '0;
        calm                    = 1'b0;
        clock_ms                = '0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Evaluations inside the startup silence give nothing; adverts are
        // stored already. One advert sits exactly on the strong threshold and one at
        // the top level; the others miss on level, company flag or company id.
        send_item(CMD_EVAL,   32'd0,   -8'sd60,  1'b1, WANTED_COMPANY);
        send_item(CMD_ADVERT, 32'd100, -8'sd56,  1'b1, WANTED_COMPANY);
        send_item(CMD_ADVERT, 32'd200, -8'sd57,  1'b1, WANTED_COMPANY);
        send_item(CMD_ADVERT, 32'd300, -8'sd40,  1'b0, WANTED_COMPANY);
        send_item(CMD_ADVERT, 32'd400, -8'sd30,  1'b1, WANTED_COMPANY ^ 16'h0001);
        send_item(CMD_ADVERT, 32'd500, 8'sd127,  1'b1, WANTED_COMPANY);
        send_item(CMD_ADVERT, 32'd600, 8'sh80,   1'b1, 16'hFFFF);
        send_item(CMD_EVAL,   32'd3999, 8'sd0,   1'b0, 16'h0000);
        // The first evaluation at the end of the silence always reports a
        // change; two strong hits, one of them very strong, switch presence on.
        send_item(CMD_EVAL,   32'd4000, 8'sd0,   1'b0, 16'h0000);
        send_item(CMD_EVAL,   32'd4250, 8'sd0,   1'b0, 16'h0000);
        // A hit exactly on the very strong threshold, then evaluations right at
        // and one past the very strong age, and exactly at the window edge.
        send_item(CMD_ADVERT, 32'd4300,  -8'sd52, 1'b1, WANTED_COMPANY);
        send_item(CMD_EVAL,   32'd19300, 8'sd0,   1'b0, 16'h0000);
        send_item(CMD_EVAL,   32'd19301, 8'sd0,   1'b0, 16'h0000);
        send_item(CMD_EVAL,   32'd20500, 8'sd0,   1'b0, 16'h0000);
        // A stamp from the future is pruned; with no strong hit left the gap
        // reads as none and presence drops.
        send_item(CMD_ADVERT, 32'd30000, -8'sd50, 1'b1, WANTED_COMPANY);
        send_item(CMD_EVAL,   32'd25000, 8'sd0,   1'b0, 16'h0000);
        send_item(CMD_ADVERT, 32'd25100, -8'sd60, 1'b1, WANTED_COMPANY);
        send_item(CMD_EVAL,   32'd25200, 8'sd0,   1'b0, 16'h0000);
        // Hits just before the timestamp wraps, evaluated just after it.
        send_item(CMD_ADVERT, 32'hFFFF_FF00, -8'sd45, 1'b1, WANTED_COMPANY);
        send_item(CMD_ADVERT, 32'hFFFF_FF80, -8'sd50, 1'b1, WANTED_COMPANY);
        send_item(CMD_EVAL,   32'hFFFF_FFFF, 8'sd0,   1'b0, 16'h0000);
        send_item(CMD_EVAL,   32'h0000_0100, 8'sd0,   1'b0, 16'h0000);

        clock_ms = 32'h0000_0200;
        run_traffic(USEFUL_PER_SETTING, 1'b1);

        for (int p = 1; p < SETTING_COUNT; p++) begin
            settle();
            apply_setting(make_setting(p));
            calm = (p % 3 == 1);
            // One setting starts shortly before the timestamp wraps.
            if (p == 3)
                clock_ms = 32'hFFFF_F000;
            run_traffic(USEFUL_PER_SETTING, p == 2);
        end

        calm = 1'b0;
        settle();

        $display("Ran %0d register settings: %0d evaluations, %0d decisions checked.",
                 SETTING_COUNT, sb.evals_taken, sb.decisions_checked);
        $display("Stored %0d hits, %0d pushed out of a full store, presence came on %0d times.",
                 sb.hits_stored, sb.hits_dropped, sb.entries);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/rpd_pkg.sv
hw/rtl/rpd_item_if.sv
hw/rtl/rpd_result_if.sv
hw/rtl/rpd_ctrl.sv
hw/rtl/rpd_datapath.sv
hw/rtl/rssi_presence_detector_core.sv
verif/tb_top.sv
